/* hdl/assert_macros.svh */
// assert_macros.svh: assertion shorthands for the checker files.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ART_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ART_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/art_pkg.sv */
// art_pkg: shared types, constants and codes of the address region table.
// No dependencies; used by every module of the block except art_ram.
package art_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int MAX_TRIES   = 4096;

  localparam int PB     = $clog2(PAGE_BYTES);
  localparam int PW     = 64 - PB;
  localparam int IDX_W  = $clog2(MAX_REGIONS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int TRY_W  = $clog2(MAX_TRIES + 1);

  localparam logic [32:0] ALLOC_LIMIT = 33'h1_0000_0000;
  localparam logic [3:0]  KIND_MMAP   = 4'd3;

  localparam logic [2:0] CMD_MAP    = 3'd0;
  localparam logic [2:0] CMD_ALLOC  = 3'd1;
  localparam logic [2:0] CMD_UNMAP  = 3'd2;
  localparam logic [2:0] CMD_PROT   = 3'd3;
  localparam logic [2:0] CMD_LOOKUP = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERLAP   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_NO_GAP    = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] addr;
    logic [32:0] len;
    logic [2:0]  prot;
    logic [3:0]  kind;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] result_base;
    logic [32:0] result_size;
    logic [2:0]  result_prot;
    logic [3:0]  result_kind;
  } out_item_t;

  typedef struct packed {
    logic [63:0] base;
    logic [32:0] size;
    logic [2:0]  prot;
    logic [3:0]  kind;
  } region_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_SCAN_INIT,
    OP_EVAL,
    OP_ADVANCE,
    OP_SHIFT_INIT,
    OP_SH_READ,
    OP_SH_WRITE,
    OP_INSERT,
    OP_COMPACT,
    OP_PROT_WR,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       range_bad;
    logic       size_wide;
    logic       len_big;
    logic       full;
    logic       ovf;
    logic       tries_max;
    logic       hit;
    logic       removed;
    logic       scan_end;
    logic       sh_more;
  } dp_sts_t;

endpackage

/* hdl/art_ram.sv */
// art_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/art_ctrl.sv */
// art_ctrl: sequencer for the region table commands.
// Depends on art_pkg; drives art_dp through dp_cmd_t, reads dp_sts_t.
module art_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  art_pkg::dp_sts_t sts,
  output art_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CHECK, S_RD, S_EV, S_POST, S_SH_RD, S_SH_WR, S_INS, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  art_pkg::status_t  code_r, code_nxt;
  logic              out_valid_r, out_valid_nxt;
  art_pkg::dp_op_t   op;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = art_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = art_pkg::OP_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        op        = art_pkg::OP_PREP;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_FIN;
        unique case (sts.cmd)
          art_pkg::CMD_MAP: begin
            if (sts.range_bad || sts.size_wide) begin
              code_nxt = art_pkg::ST_TOO_LARGE;
            end else begin
              op        = art_pkg::OP_SCAN_INIT;
              state_nxt = S_RD;
            end
          end
          art_pkg::CMD_ALLOC: begin
            priority if (sts.len_big) begin
              code_nxt = art_pkg::ST_TOO_LARGE;
            end else if (sts.full) begin
              code_nxt = art_pkg::ST_FULL;
            end else if (sts.tries_max || sts.ovf) begin
              code_nxt = art_pkg::ST_NO_GAP;
            end else begin
              op        = art_pkg::OP_SCAN_INIT;
              state_nxt = S_RD;
            end
          end
          art_pkg::CMD_UNMAP, art_pkg::CMD_PROT: begin
            if (sts.range_bad) begin
              code_nxt = art_pkg::ST_NOT_FOUND;
            end else begin
              op        = art_pkg::OP_SCAN_INIT;
              state_nxt = S_RD;
            end
          end
          art_pkg::CMD_LOOKUP: begin
            op        = art_pkg::OP_SCAN_INIT;
            state_nxt = S_RD;
          end
          default: code_nxt = art_pkg::ST_NOT_FOUND;
        endcase
      end
      S_RD: begin
        // Scan stops at end of table or on the first hit.
        if (sts.hit || sts.scan_end) begin
          state_nxt = S_POST;
        end else begin
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        op        = art_pkg::OP_EVAL;
        state_nxt = S_RD;
      end
      S_POST: begin
        state_nxt = S_FIN;
        unique case (sts.cmd)
          art_pkg::CMD_MAP: begin
            priority if (sts.hit) begin
              code_nxt = art_pkg::ST_OVERLAP;
            end else if (sts.full) begin
              code_nxt = art_pkg::ST_FULL;
            end else begin
              op        = art_pkg::OP_SHIFT_INIT;
              state_nxt = S_SH_RD;
            end
          end
          art_pkg::CMD_ALLOC: begin
            if (sts.hit) begin
              op        = art_pkg::OP_ADVANCE;
              state_nxt = S_CHECK;
            end else begin
              op        = art_pkg::OP_SHIFT_INIT;
              state_nxt = S_SH_RD;
            end
          end
          art_pkg::CMD_UNMAP: begin
            op       = art_pkg::OP_COMPACT;
            code_nxt = sts.removed ? art_pkg::ST_OK : art_pkg::ST_NOT_FOUND;
          end
          art_pkg::CMD_PROT: begin
            if (sts.hit) begin
              op       = art_pkg::OP_PROT_WR;
              code_nxt = art_pkg::ST_OK;
            end else begin
              code_nxt = art_pkg::ST_NOT_FOUND;
            end
          end
          default: code_nxt = sts.hit ? art_pkg::ST_OK : art_pkg::ST_NOT_FOUND;
        endcase
      end
      S_SH_RD: begin
        if (sts.sh_more) begin
          op        = art_pkg::OP_SH_READ;
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_SH_WR: begin
        op        = art_pkg::OP_SH_WRITE;
        state_nxt = S_SH_RD;
      end
      S_INS: begin
        op        = art_pkg::OP_INSERT;
        code_nxt  = art_pkg::ST_OK;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          op            = art_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= art_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.op    = op;
  assign cmd.code  = code_r;

endmodule

/* hdl/art_dp.sv */
// art_dp: region table datapath: table RAM, range math, scan compares, result.
// Depends on art_pkg and art_ram; commanded by art_ctrl.
module art_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  art_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  input  art_pkg::dp_cmd_t   cmd,
  output art_pkg::dp_sts_t   sts,
  output art_pkg::out_item_t out_data
);

  localparam int PB    = art_pkg::PB;
  localparam int PW    = art_pkg::PW;
  localparam int IDX_W = art_pkg::IDX_W;
  localparam int CNT_W = art_pkg::CNT_W;
  localparam int TRY_W = art_pkg::TRY_W;

  art_pkg::in_item_t  in_r;
  logic [64:0]        sum_r;
  logic [63:0]        base_r, end_r, hit_end_r, cursor_r;
  logic [32:0]        size_r;
  logic               wide_r, range_bad_r, len_big_r;
  logic [CNT_W-1:0]   idx_r, wr_r, pos_r, count_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic               pos_found_r, hit_r, removed_r;
  logic [TRY_W-1:0]   tries_r;
  art_pkg::region_t   hit_ent_r;
  art_pkg::out_item_t out_r;

  // Table RAM
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  art_pkg::region_t   wdata, ent;

  art_ram #(.WIDTH($bits(art_pkg::region_t)), .DEPTH(art_pkg::MAX_REGIONS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ent)
  );

  // Page-aligned range of the request (fixed map, unmap, protect) and allocate size
  logic [PW-1:0] end_pg, size_pg, alloc_pg;
  logic [63:0]   fx_size64, al_size64;
  always_comb begin
    end_pg    = sum_r[63:PB] + PW'(|sum_r[PB-1:0]);
    size_pg   = end_pg - in_r.addr[63:PB];
    fx_size64 = {size_pg, {PB{1'b0}}};
    if (in_r.len == '0) begin
      alloc_pg = PW'(1);
    end else begin
      alloc_pg = PW'(in_r.len[32:PB]) + PW'(|in_r.len[PB-1:0]);
    end
    al_size64 = {alloc_pg, {PB{1'b0}}};
  end

  // Scan compares on the entry read back this cycle
  logic [63:0] ent_end;
  logic        clash, match, inside_hit;
  logic [64:0] cand_sum;
  always_comb begin
    ent_end    = ent.base + 64'(ent.size);
    clash      = (base_r < ent_end) && (ent.base < end_r);
    match      = (ent.base == base_r) && (ent.size == size_r) && !wide_r;
    inside_hit = (in_r.addr >= ent.base) && (in_r.addr < ent_end);
    cand_sum   = {1'b0, base_r} + 65'(size_r);
  end

  // RAM ports
  always_comb begin
    we    = 1'b0;
    waddr = idx_r[IDX_W-1:0];
    wdata = ent;
    raddr = idx_r[IDX_W-1:0];
    unique case (cmd.op)
      art_pkg::OP_SH_READ: raddr = IDX_W'(idx_r - CNT_W'(1));
      art_pkg::OP_SH_WRITE: we = 1'b1;
      art_pkg::OP_EVAL: begin
        if (in_r.cmd == art_pkg::CMD_UNMAP && !match) begin
          we    = 1'b1;
          waddr = wr_r[IDX_W-1:0];
        end
      end
      art_pkg::OP_INSERT: begin
        we    = 1'b1;
        waddr = pos_r[IDX_W-1:0];
        wdata = '{base: base_r, size: size_r, prot: in_r.prot,
                  kind: (in_r.cmd == art_pkg::CMD_ALLOC) ? art_pkg::KIND_MMAP
                                                          : in_r.kind};
      end
      art_pkg::OP_PROT_WR: begin
        we    = 1'b1;
        waddr = hit_idx_r;
        wdata = '{base: hit_ent_r.base, size: hit_ent_r.size, prot: in_r.prot,
                  kind: hit_ent_r.kind};
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= 64'h4000_0000;
    end else begin
      if (cmd.op == art_pkg::OP_INSERT) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.op == art_pkg::OP_COMPACT) begin
        count_r <= wr_r;
      end
      if (cfg_we) begin
        cursor_r <= cfg_wdata;
      end else if (cmd.op == art_pkg::OP_INSERT && in_r.cmd == art_pkg::CMD_ALLOC) begin
        cursor_r <= cand_sum[63:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      art_pkg::OP_LOAD: begin
        in_r  <= in_data;
        sum_r <= {1'b0, in_data.addr} + 65'(in_data.len);
      end
      art_pkg::OP_PREP: begin
        range_bad_r <= sum_r[64] || ((&sum_r[63:PB]) && (|sum_r[PB-1:0]));
        len_big_r   <= in_r.len > art_pkg::ALLOC_LIMIT;
        tries_r     <= '0;
        if (in_r.cmd == art_pkg::CMD_ALLOC) begin
          base_r <= cursor_r;
          size_r <= al_size64[32:0];
          wide_r <= 1'b0;
        end else begin
          base_r <= {in_r.addr[63:PB], {PB{1'b0}}};
          size_r <= fx_size64[32:0];
          wide_r <= |fx_size64[63:33];
        end
      end
      art_pkg::OP_SCAN_INIT: begin
        idx_r       <= '0;
        wr_r        <= '0;
        pos_r       <= count_r;
        pos_found_r <= 1'b0;
        hit_r       <= 1'b0;
        removed_r   <= 1'b0;
        end_r       <= cand_sum[63:0];
      end
      art_pkg::OP_EVAL: begin
        idx_r <= idx_r + CNT_W'(1);
        unique case (in_r.cmd)
          art_pkg::CMD_MAP, art_pkg::CMD_ALLOC: begin
            if (clash) begin
              hit_r     <= 1'b1;
              hit_end_r <= ent_end;
            end
            if (!pos_found_r && ent.base > base_r) begin
              pos_r       <= idx_r;
              pos_found_r <= 1'b1;
            end
          end
          art_pkg::CMD_UNMAP: begin
            if (match) begin
              if (!removed_r) hit_ent_r <= ent;
              removed_r <= 1'b1;
            end else begin
              wr_r <= wr_r + CNT_W'(1);
            end
          end
          art_pkg::CMD_PROT: begin
            if (match) begin
              hit_r     <= 1'b1;
              hit_idx_r <= idx_r[IDX_W-1:0];
              hit_ent_r <= ent;
            end
          end
          default: begin
            if (inside_hit) begin
              hit_r     <= 1'b1;
              hit_ent_r <= ent;
            end
          end
        endcase
      end
      art_pkg::OP_ADVANCE: begin
        base_r  <= hit_end_r;
        tries_r <= tries_r + TRY_W'(1);
      end
      art_pkg::OP_SHIFT_INIT: idx_r <= count_r;
      art_pkg::OP_SH_WRITE:   idx_r <= idx_r - CNT_W'(1);
      art_pkg::OP_FINISH: begin
        out_r <= '0;
        out_r.status <= cmd.code;
        if (cmd.code == art_pkg::ST_OK) begin
          out_r.result_base <= base_r;
          out_r.result_size <= size_r;
          out_r.result_prot <= in_r.prot;
          out_r.result_kind <= in_r.kind;
          unique case (in_r.cmd)
            art_pkg::CMD_ALLOC: out_r.result_kind <= art_pkg::KIND_MMAP;
            art_pkg::CMD_UNMAP: begin
              out_r.result_prot <= hit_ent_r.prot;
              out_r.result_kind <= hit_ent_r.kind;
            end
            art_pkg::CMD_PROT: out_r.result_kind <= hit_ent_r.kind;
            art_pkg::CMD_LOOKUP: begin
              out_r.result_base <= hit_ent_r.base;
              out_r.result_size <= hit_ent_r.size;
              out_r.result_prot <= hit_ent_r.prot;
              out_r.result_kind <= hit_ent_r.kind;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.cmd       = in_r.cmd;
    sts.range_bad = range_bad_r;
    sts.size_wide = wide_r;
    sts.len_big   = len_big_r;
    sts.full      = count_r == CNT_W'(art_pkg::MAX_REGIONS);
    sts.ovf       = cand_sum[64];
    sts.tries_max = tries_r == TRY_W'(art_pkg::MAX_TRIES);
    sts.hit       = hit_r;
    sts.removed   = removed_r;
    sts.scan_end  = idx_r == count_r;
    sts.sh_more   = idx_r > pos_r;
  end

  assign out_data = out_r;

endmodule

/* hdl/address_region_table_core.sv */
// address_region_table_core: top level of the sorted address region table.
// Depends on art_pkg, art_ctrl, art_dp (which holds art_ram).
//
//   channel   ports                               transfer when
//   input     in_valid, in_ready, in_data         in_valid && in_ready
//   result    out_valid, out_ready, out_data      out_valid && out_ready
//   config    cfg_we, cfg_wdata (alloc_start)     cfg_we
//
// One command at a time. A table scan reads each region from the RAM and then
// compares it; fixed map and allocate then move each region from the insert
// position up by one slot (read, then write) before the sorted insert, and allocate
// repeats the scan once per clashing region it skips (up to MAX_TRIES scans).
// The registered read of the table RAM is why each read comes before its compare.
// Reset (rst_n low, synchronous) empties the table and loads the cursor with
// 0x40000000; table contents are not cleared. A config write also loads the
// cursor. A held result does not block the next input transfer; only the
// finish of that next command waits for the output register to drain.
module address_region_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  art_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output art_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata
);

  art_pkg::dp_cmd_t dp_cmd;
  art_pkg::dp_sts_t dp_sts;

  // Sequencer: accepts a transfer, walks scan/shift/insert steps, hands off result.
  art_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // Datapath: table RAM, page math, per-entry compares, cursor, output register.
  art_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .out_data (out_data)
  );

endmodule

/* hdl/art_checker.sv */
// art_checker: port-level assertions for address_region_table_core.
// Depends on art_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module art_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input art_pkg::out_item_t out_data
);

  logic out_stall, in_take, err_out, err_data;

  assign out_stall = out_valid && !out_ready;
  assign in_take   = in_valid && in_ready;
  assign err_out   = out_valid && (out_data.status != art_pkg::ST_OK);
  assign err_data  = (out_data.result_base != '0) || (out_data.result_size != '0) ||
                     (out_data.result_prot != '0) || (out_data.result_kind != '0);

  `ART_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid, "result dropped")
  `ART_ASSERT_NEXT(a_busy, clk, rst_n, in_take, !in_ready, "transfer taken while busy")
  `ART_ASSERT_NOW(a_err_zero, clk, rst_n, err_out, !err_data, "error result carries data")
  `ART_ASSERT_NOW(a_status, clk, rst_n, out_valid, out_data.status <= art_pkg::ST_NO_GAP, "bad status")

endmodule

bind address_region_table_core art_checker u_art_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
